@@ sv/bcc_pkg.sv @@
// Shared types and constants for the barometer compensation pipeline.
package bcc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VARIANT     = 3'd0,
      CSR_PRESS_SENS  = 3'd1,
      CSR_PRESS_OFF   = 3'd2,
      CSR_SENS_TCO    = 3'd3,
      CSR_OFF_TCO     = 3'd4,
      CSR_REF_TEMP    = 3'd5,
      CSR_TEMP_SLOPE  = 3'd6
   } csr_index_type;

   // 20.00 C and -15.00 C break points, in 0.01 C
   localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
   localparam logic signed [19:0] TEMP_COLD = -20'sd1500;

   typedef struct packed {
      logic        variant_select;
      logic [15:0] pressure_sensitivity;
      logic [15:0] pressure_offset;
      logic [15:0] sens_temp_coef;
      logic [15:0] offset_temp_coef;
      logic [15:0] reference_temp;
      logic [15:0] temp_slope;
   } cfg_type;

   // first-order results
   typedef struct packed {
      logic [23:0]        raw_pressure;
      logic signed [19:0] temp;
      logic signed [40:0] off;
      logic signed [40:0] sens;
      logic [17:0]        dt_sq;
   } first_type;

   // after second-order correction
   typedef struct packed {
      logic [23:0]        raw_pressure;
      logic signed [19:0] temp;
      logic signed [42:0] off;
      logic signed [42:0] sens;
   } second_type;

endpackage

@@ sv/barometer_compensation_core.sv @@
// Nine register stages; rsp_tvalid is the valid bit of the ninth.
// Throughput: one word per cycle unless rsp_tready stalls; every stage has its own valid and
// load enable, so a stalled rsp side holds words in place while empty stages still fill from req.
// Reset clears all stage valid bits and the calibration registers to zero.
// Four parallel multipliers on dT, two squarers, then D1*SENS in two partial products.
module barometer_compensation_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [47:0]                       req_tdata,  // raw_pressure, raw_temperature
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [55:0]                       rsp_tdata   // pressure_pa, temp_centideg, 0 pad
);

   bcc_pkg::cfg_type    cfg;
   bcc_pkg::first_type  first_data;
   bcc_pkg::second_type second_data;
   logic                first_valid, first_ready;
   logic                second_valid, second_ready;
   logic signed [31:0]  pressure_pa;
   logic signed [18:0]  temp_centideg;

   bcc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcc_first u_first (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .raw_pressure    (req_tdata[23:0]),
      .raw_temperature (req_tdata[47:24]),
      .out_valid       (first_valid),
      .out_ready       (first_ready),
      .out_data        (first_data)
   );

   bcc_second u_second (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (first_valid),
      .in_ready  (first_ready),
      .in_data   (first_data),
      .out_valid (second_valid),
      .out_ready (second_ready),
      .out_data  (second_data)
   );

   bcc_press u_press (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (second_valid),
      .in_ready      (second_ready),
      .in_data       (second_data),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .pressure_pa   (pressure_pa),
      .temp_centideg (temp_centideg)
   );

   assign rsp_tdata = {5'b0, temp_centideg, pressure_pa};

endmodule

@@ sv/bcc_cfg.sv @@
// Calibration and variant registers written through the csr port.
module bcc_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output bcc_pkg::cfg_type                     cfg
);

   bcc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bcc_pkg::CSR_VARIANT:    cfg_ff.variant_select       <= csr_wdata[0];
            bcc_pkg::CSR_PRESS_SENS: cfg_ff.pressure_sensitivity <= csr_wdata;
            bcc_pkg::CSR_PRESS_OFF:  cfg_ff.pressure_offset      <= csr_wdata;
            bcc_pkg::CSR_SENS_TCO:   cfg_ff.sens_temp_coef       <= csr_wdata;
            bcc_pkg::CSR_OFF_TCO:    cfg_ff.offset_temp_coef     <= csr_wdata;
            bcc_pkg::CSR_REF_TEMP:   cfg_ff.reference_temp       <= csr_wdata;
            bcc_pkg::CSR_TEMP_SLOPE: cfg_ff.temp_slope           <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/bcc_first.sv @@
// Stages 1-3: dT, the four products on dT, first-order TEMP/OFF/SENS.
module bcc_first (
   input  logic                 clock,
   input  logic                 reset,
   input  bcc_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [23:0]          raw_pressure,
   input  logic [23:0]          raw_temperature,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bcc_pkg::first_type   out_data
);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // stage 1
   logic signed [24:0] dt_in, dt_ff;
   logic [23:0]        d1a_ff;
   // stage 2
   logic signed [41:0] mt_in, mo_in, ms_in, mt_ff, mo_ff, ms_ff;
   logic signed [49:0] mdd_in, mdd_ff;
   logic [23:0]        d1b_ff;
   // stage 3
   bcc_pkg::first_type res_in, res_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.reference_temp, 8'b0});

   assign mt_in  = dt_ff * $signed({1'b0, cfg.temp_slope});
   assign mo_in  = dt_ff * $signed({1'b0, cfg.offset_temp_coef});
   assign ms_in  = dt_ff * $signed({1'b0, cfg.sens_temp_coef});
   assign mdd_in = dt_ff * dt_ff;

   always_comb begin
      res_in.raw_pressure = d1b_ff;
      res_in.temp  = $signed({mt_ff[41], mt_ff[41:23]}) + bcc_pkg::TEMP_REF;
      res_in.dt_sq = mdd_ff[48:31];
      if (cfg.variant_select) begin
         res_in.off  = $signed({8'b0, cfg.pressure_offset, 17'b0})
                     + $signed({{5{mo_ff[41]}}, mo_ff[41:6]});
         res_in.sens = $signed({9'b0, cfg.pressure_sensitivity, 16'b0})
                     + $signed({{6{ms_ff[41]}}, ms_ff[41:7]});
      end else begin
         res_in.off  = $signed({9'b0, cfg.pressure_offset, 16'b0})
                     + $signed({{6{mo_ff[41]}}, mo_ff[41:7]});
         res_in.sens = $signed({10'b0, cfg.pressure_sensitivity, 15'b0})
                     + $signed({{7{ms_ff[41]}}, ms_ff[41:8]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dt_ff  <= dt_in;
         d1a_ff <= raw_pressure;
      end
      if (rdy2) begin
         mt_ff  <= mt_in;
         mo_ff  <= mo_in;
         ms_ff  <= ms_in;
         mdd_ff <= mdd_in;
         d1b_ff <= d1a_ff;
      end
      if (rdy3) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = res_ff;

endmodule

@@ sv/bcc_second.sv @@
// Stages 4-6: second-order corrections below 20 C and below -15 C.
module bcc_second (
   input  logic                 clock,
   input  logic                 reset,
   input  bcc_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bcc_pkg::first_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bcc_pkg::second_type  out_data
);

   logic v4_ff, v5_ff, v6_ff;
   logic rdy4, rdy5, rdy6;

   // stage 4: squares and range flags
   logic signed [19:0] t_in, u_in;
   logic signed [39:0] dsq_in, esq_in;
   logic [34:0]        d_ff, e_ff;
   logic               warm_lt_in, cold_lt_in;
   logic               warm4_ff, cold4_ff, warm5_ff;
   bcc_pkg::first_type f4_ff, f5_ff;

   // stage 5: correction terms
   logic [41:0] dx, ex, off_a, off_b, sens_a, sens_b, coff_in, csens_in, coff_ff, csens_ff;

   // stage 6
   bcc_pkg::second_type res_in, res_ff;

   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   assign t_in       = in_data.temp - bcc_pkg::TEMP_REF;
   assign u_in       = in_data.temp - bcc_pkg::TEMP_COLD;
   assign dsq_in     = t_in * t_in;
   assign esq_in     = u_in * u_in;
   assign warm_lt_in = in_data.temp < bcc_pkg::TEMP_REF;
   assign cold_lt_in = in_data.temp < bcc_pkg::TEMP_COLD;

   assign dx = {7'b0, d_ff};
   assign ex = {7'b0, e_ff};

   always_comb begin
      if (cfg.variant_select) begin
         off_a  = (dx * 42'd61) >> 4;
         off_b  = ex * 42'd15;
         sens_a = dx << 1;
         sens_b = ex << 3;
      end else begin
         off_a  = (dx * 42'd5) >> 1;
         off_b  = ex * 42'd7;
         sens_a = (dx * 42'd5) >> 2;
         sens_b = (ex * 42'd11) >> 1;
      end
      coff_in  = (warm4_ff ? off_a : 42'd0) + (cold4_ff ? off_b : 42'd0);
      csens_in = (warm4_ff ? sens_a : 42'd0) + (cold4_ff ? sens_b : 42'd0);
   end

   always_comb begin
      res_in.raw_pressure = f5_ff.raw_pressure;
      res_in.off  = $signed({{2{f5_ff.off[40]}}, f5_ff.off}) - $signed({1'b0, coff_ff});
      res_in.sens = $signed({{2{f5_ff.sens[40]}}, f5_ff.sens}) - $signed({1'b0, csens_ff});
      // dT^2 term only applies below 20 C
      res_in.temp = f5_ff.temp - (warm5_ff ? $signed({2'b0, f5_ff.dt_sq}) : 20'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         d_ff     <= dsq_in[34:0];
         e_ff     <= esq_in[34:0];
         warm4_ff <= warm_lt_in;
         cold4_ff <= cold_lt_in;
         f4_ff    <= in_data;
      end
      if (rdy5) begin
         coff_ff  <= coff_in;
         csens_ff <= csens_in;
         warm5_ff <= warm4_ff;
         f5_ff    <= f4_ff;
      end
      if (rdy6) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = res_ff;

endmodule

@@ sv/bcc_press.sv @@
// Stages 7-9: D1*SENS as two partial products, then the pressure result.
module bcc_press (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bcc_pkg::second_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [31:0]   pressure_pa,
   output logic signed [18:0]   temp_centideg
);

   logic v7_ff, v8_ff, v9_ff;
   logic rdy7, rdy8, rdy9;

   // stage 7
   logic [43:0]        plo_in, plo_ff;
   logic signed [47:0] phi_in, phi_ff;
   logic signed [42:0] off7_ff, off8_ff;
   logic signed [19:0] temp7_ff, temp8_ff;
   // stage 8
   logic signed [67:0] prod;
   logic signed [46:0] q_in, q_ff;
   // stage 9
   logic signed [47:0] r;
   logic signed [31:0] p_in, p_ff;
   logic signed [18:0] t_ff;

   assign rdy9     = !v9_ff || out_ready;
   assign rdy8     = !v8_ff || rdy9;
   assign rdy7     = !v7_ff || rdy8;
   assign in_ready = rdy7;

   // SENS split into a signed upper 23 bits and an unsigned low 20 bits
   assign plo_in = in_data.raw_pressure * in_data.sens[19:0];
   assign phi_in = $signed({1'b0, in_data.raw_pressure}) * $signed(in_data.sens[42:20]);

   assign prod = $signed({phi_ff, 20'b0}) + $signed({24'b0, plo_ff});
   assign q_in = prod[67:21];

   assign r    = $signed({q_ff[46], q_ff}) - $signed({{5{off8_ff[42]}}, off8_ff});
   assign p_in = r[46:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         if (rdy7) v7_ff <= in_valid;
         if (rdy8) v8_ff <= v7_ff;
         if (rdy9) v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy7) begin
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         off7_ff  <= in_data.off;
         temp7_ff <= in_data.temp;
      end
      if (rdy8) begin
         q_ff     <= q_in;
         off8_ff  <= off7_ff;
         temp8_ff <= temp7_ff;
      end
      if (rdy9) begin
         p_ff <= p_in;
         t_ff <= temp8_ff[18:0];
      end
   end

   assign out_valid     = v9_ff;
   assign pressure_pa   = p_ff;
   assign temp_centideg = t_ff;

endmodule

@@ tb/tb_barometer_compensation_core.sv @@
// Self-checking testbench for barometer_compensation_core: directed table, then random phases.
`timescale 1ns / 100ps

module tb_barometer_compensation_core;

   typedef logic [bcc_pkg::CSR_INDEX_W-1:0] csr_idx_type;

   localparam int IDLE_PCT    = 7;
   localparam int WATCHDOG    = 2000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASES      = 11;
   localparam int PHASE_WORDS = 100;
   localparam int CAL_RESET   = -1;
   localparam csr_idx_type CSR_SPARE = 3'd7;  // unmapped index, writes ignored

   // packed so that pressure_pa sits in the low bits, as on rsp_tdata
   typedef struct packed {
      logic signed [18:0] temp_centideg;
      logic signed [31:0] pressure_pa;
   } reading_type;

   typedef struct {
      int          cal;
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
      bit          typed;
      reading_type want;
   } probe_type;

   typedef struct {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
      bit          typed;
      reading_type want;
   } sample_type;

   // zeroed calibration: dT terms vanish, so any pair reads 0 Pa at 20.00 C
   localparam reading_type AT_RESET = '{temp_centideg: 19'sd2000, pressure_pa: 32'sd0};

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   csr_idx_type                    csr_index = '0;
   logic [bcc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [47:0]                    req_tdata = '0;  // raw_pressure, raw_temperature
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [55:0]                    rsp_tdata;       // pressure_pa, temp_centideg, 0 pad

   barometer_compensation_core dut (.*);

   bcc_pkg::cfg_type cal = '0;
   sample_type  samples_to_send [$];
   reading_type pending_readings [$];
   sample_type  on_bus;
   reading_type got, want;
   bit       steady = 1'b0;
   int       n_queued = 0, n_sent = 0, n_checked = 0, faults = 0;
   int       n_cool = 0, n_cold = 0, n_cals = 0;
   int       quiet_cycles = 0;

   bcc_pkg::cfg_type cal_sets [4] = '{
      '{1'b0, 16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
      '{1'b1, 16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
      '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}
   };

   // warm, below 20 C and below -15 C for the typical sets; full-scale corners for every set
   probe_type probes [22] = '{
      '{CAL_RESET, 24'h000000, 24'h000000, 1'b1, AT_RESET},
      '{CAL_RESET, 24'hFFFFFF, 24'hFFFFFF, 1'b1, AT_RESET},
      '{CAL_RESET, 24'hFFFFFF, 24'h000000, 1'b1, AT_RESET},
      '{CAL_RESET, 24'h000000, 24'hFFFFFF, 1'b1, AT_RESET},
      '{0, 24'd9085466, 24'd8569150, 1'b0, '0},
      '{0, 24'd9085466, 24'd8000000, 1'b0, '0},
      '{0, 24'd9085466, 24'd6000000, 1'b0, '0},
      '{0, 24'h000000, 24'h000000, 1'b0, '0},
      '{0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{1, 24'd9085466, 24'd8569150, 1'b0, '0},
      '{1, 24'd9085466, 24'd8000000, 1'b0, '0},
      '{1, 24'd9085466, 24'd6000000, 1'b0, '0},
      '{1, 24'h000000, 24'h000000, 1'b0, '0},
      '{1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{2, 24'h000000, 24'h000000, 1'b0, '0},
      '{2, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{2, 24'h000000, 24'hFFFFFF, 1'b0, '0},
      '{3, 24'h000000, 24'h000000, 1'b0, '0},
      '{3, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{3, 24'h000000, 24'hFFFFFF, 1'b0, '0}
   };

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic reading_type compensate(logic [23:0] raw_p, logic [23:0] raw_t);
      logic signed [63:0] c1, c2, c3, c4, c5, c6, d1, dt, prod, temp, off, sens, sq, p;
      reading_type r;
      c1 = 64'(cal.pressure_sensitivity);
      c2 = 64'(cal.pressure_offset);
      c3 = 64'(cal.sens_temp_coef);
      c4 = 64'(cal.offset_temp_coef);
      c5 = 64'(cal.reference_temp);
      c6 = 64'(cal.temp_slope);
      d1 = 64'(raw_p);
      dt = 64'(raw_t) - (c5 <<< 8);
      prod = dt * c6;
      temp = bcc_pkg::TEMP_REF + (prod >>> 23);
      if (cal.variant_select) begin
         prod = c4 * dt;
         off = (c2 <<< 17) + (prod >>> 6);
         prod = c3 * dt;
         sens = (c1 <<< 16) + (prod >>> 7);
      end else begin
         prod = c4 * dt;
         off = (c2 <<< 16) + (prod >>> 7);
         prod = c3 * dt;
         sens = (c1 <<< 15) + (prod >>> 8);
      end
      // second-order terms use TEMP before the dT squared correction
      if (temp < bcc_pkg::TEMP_REF) begin
         n_cool++;
         sq = (temp - bcc_pkg::TEMP_REF) * (temp - bcc_pkg::TEMP_REF);
         if (cal.variant_select) begin
            off = off - ((sq * 64'sd61) >>> 4);
            sens = sens - (sq * 64'sd2);
         end else begin
            off = off - ((sq * 64'sd5) >>> 1);
            sens = sens - ((sq * 64'sd5) >>> 2);
         end
         if (temp < bcc_pkg::TEMP_COLD) begin
            n_cold++;
            sq = (temp - bcc_pkg::TEMP_COLD) * (temp - bcc_pkg::TEMP_COLD);
            if (cal.variant_select) begin
               off = off - (sq * 64'sd15);
               sens = sens - (sq * 64'sd8);
            end else begin
               off = off - (sq * 64'sd7);
               sens = sens - ((sq * 64'sd11) >>> 1);
            end
         end
         prod = dt * dt;
         temp = temp - (prod >>> 31);
      end
      prod = d1 * sens;
      p = ((prod >>> 21) - off) >>> 15;
      r.pressure_pa = p[31:0];
      r.temp_centideg = temp[18:0];
      return r;
   endfunction

   function automatic void apply_csr(csr_idx_type idx,
                                     logic [bcc_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         bcc_pkg::CSR_VARIANT:    cal.variant_select = val[0];
         bcc_pkg::CSR_PRESS_SENS: cal.pressure_sensitivity = val;
         bcc_pkg::CSR_PRESS_OFF:  cal.pressure_offset = val;
         bcc_pkg::CSR_SENS_TCO:   cal.sens_temp_coef = val;
         bcc_pkg::CSR_OFF_TCO:    cal.offset_temp_coef = val;
         bcc_pkg::CSR_REF_TEMP:   cal.reference_temp = val;
         bcc_pkg::CSR_TEMP_SLOPE: cal.temp_slope = val;
         default: ;
      endcase
   endfunction

   // caller makes sure the pipeline is empty
   task automatic program_cal(bcc_pkg::cfg_type c);
      logic [bcc_pkg::CSR_DATA_W-1:0] words [8];
      int last;
      // upper bits of the variant word are junk; only bit 0 is kept
      words[bcc_pkg::CSR_VARIANT]    = {15'($urandom), c.variant_select};
      words[bcc_pkg::CSR_PRESS_SENS] = c.pressure_sensitivity;
      words[bcc_pkg::CSR_PRESS_OFF]  = c.pressure_offset;
      words[bcc_pkg::CSR_SENS_TCO]   = c.sens_temp_coef;
      words[bcc_pkg::CSR_OFF_TCO]    = c.offset_temp_coef;
      words[bcc_pkg::CSR_REF_TEMP]   = c.reference_temp;
      words[bcc_pkg::CSR_TEMP_SLOPE] = c.temp_slope;
      words[CSR_SPARE]               = 16'($urandom);
      last = $urandom_range(1) ? int'(CSR_SPARE) : int'(bcc_pkg::CSR_TEMP_SLOPE);
      for (int i = int'(bcc_pkg::CSR_VARIANT); i <= last; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_wdata <= words[i];
         @(posedge clock);
         apply_csr(csr_idx_type'(i), words[i]);
      end
      csr_wr_en <= 1'b0;
      n_cals++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (n_sent != n_queued || pending_readings.size() != 0);
   endtask

   function automatic void queue_sample(logic [23:0] raw_p, logic [23:0] raw_t, bit typed,
                                        reading_type want);
      sample_type s;
      s = '{raw_p, raw_t, typed, want};
      samples_to_send.push_back(s);
      n_queued++;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // req side: hold the word until taken, then maybe pause
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_readings.push_back(on_bus.typed ? on_bus.want :
                                       compensate(on_bus.raw_pressure, on_bus.raw_temperature));
            n_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               on_bus = samples_to_send.pop_front();
               req_tdata <= {on_bus.raw_temperature, on_bus.raw_pressure};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || $urandom_range(99) >= IDLE_PCT;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[50:0];
         if (pending_readings.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected word: pressure_pa %0d temp_centideg %0d",
                        got.pressure_pa, got.temp_centideg);
         end else begin
            want = pending_readings.pop_front();
            n_checked++;
            if (got.pressure_pa !== want.pressure_pa ||
                got.temp_centideg !== want.temp_centideg || rsp_tdata[55:51] !== '0) begin
               faults++;
               if (faults <= 10)
                  $display("mismatch on word %0d: pressure_pa exp %0d got %0d, %s%0d got %0d%s",
                           n_checked, want.pressure_pa, got.pressure_pa, "temp_centideg exp ",
                           want.temp_centideg, got.temp_centideg,
                           rsp_tdata[55:51] !== '0 ? ", pad not zero" : "");
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG);
         $display("[barometer_compensation_core] ERROR");
         $finish;
      end
   end

   initial begin
      int loaded;
      int ref_raw, span, t;
      logic [23:0] raw_p, raw_t;
      loaded = CAL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         if (probes[i].cal != loaded) begin
            wait_idle();
            program_cal(cal_sets[probes[i].cal]);
            loaded = probes[i].cal;
         end
         queue_sample(probes[i].raw_pressure, probes[i].raw_temperature, probes[i].typed,
                      probes[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         steady = (ph == 4);
         program_cal('{1'($urandom_range(1)), pick_word(), pick_word(), pick_word(),
                       pick_word(), pick_word(), pick_word()});
         ref_raw = int'(cal.reference_temp) * 256;
         repeat (PHASE_WORDS) begin
            case ($urandom_range(7))
               0: raw_p = 24'h000000;
               1: raw_p = 24'hFFFFFF;
               default: raw_p = 24'($urandom);
            endcase
            // half the words sit around or below the reference so the cold branches get exercised
            case ($urandom_range(5))
               0, 1: raw_t = 24'($urandom);
               2: raw_t = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
               3, 4: begin
                  span = 1 << $urandom_range(20, 4);
                  t = ref_raw + $urandom_range(2 * span) - span;
                  raw_t = t < 0 ? 24'h000000 : (t > 24'hFFFFFF ? 24'hFFFFFF : 24'(t));
               end
               default: raw_t = 24'($urandom_range(ref_raw));
            endcase
            queue_sample(raw_p, raw_t, 1'b0, '0);
         end
      end

      wait_idle();
      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      faults += pending_readings.size();
      $display("%0d words compared against the predictor over %0d calibration settings,",
               n_checked, n_cals);
      $display("%0d below 20 C and %0d of those below -15 C, with both variants and stalls",
               n_cool, n_cold);
      if (faults == 0)
         $display("[barometer_compensation_core] OK");
      else
         $display("[barometer_compensation_core] ERROR");
      $finish;
   end

endmodule
